// File: rtl/rre_pkg.sv
// Package for the RTT/RTO estimator: payload structs, event codes and fixed constants.
// No dependencies; every rre_* module uses it.
package rre_pkg;

	// event codes carried by the action field
	typedef enum logic [1:0] {
		ACT_NEW     = 2'd0,
		ACT_TIMEOUT = 2'd1,
		ACT_SAMPLE  = 2'd2,
		ACT_NONE    = 2'd3
	} act_t;

	// configuration register indexes
	localparam logic [1:0] CFG_MIN_TIMEOUT = 2'd0;
	localparam logic [1:0] CFG_MAX_TIMEOUT = 2'd1;
	localparam logic [1:0] CFG_MAX_RETRIES = 2'd2;

	localparam int SAMPLE_W   = 20;
	localparam int SEC_W      = 13;
	localparam int RETRY_W    = 5;
	localparam int LIMIT_W    = 4;
	localparam int CFG_W      = 8;
	localparam int BOUND_MS_W = 18;     // 255 s expressed in ms
	localparam int MS_PER_S   = 1000;

	localparam int RST_MIN_S       = 2;
	localparam int RST_MAX_S       = 60;
	localparam int RST_MAX_RETRIES = 3;
	localparam int RST_DEV_MS      = 750;
	localparam int HALF_S_MS       = 500;

	// seconds conversion: u = whole ms after rounding, secs = (u >> 3) / 125
	localparam int SEC_U_W   = 26;
	localparam int SEC_DIV_W = 20;
	localparam int SEC_SAT   = 8191;
	localparam int U_SAT     = 8192000; // u at or above this saturates the seconds field
	localparam int RECIP_W   = 24;
	localparam int RECIP_SH  = 30;
	localparam logic [RECIP_W-1:0] RECIP_125 = 24'd8589935; // ceil(2^30 / 125)

	localparam int QUEUE_DEPTH = 2;

	typedef struct packed {
		logic [1:0]          action;
		logic [SAMPLE_W-1:0] sample_ms;
	} evt_t;

	typedef struct packed {
		logic [SEC_W-1:0]   timeout_s;
		logic               give_up;
		logic [RETRY_W-1:0] retry_count;
	} res_t;

	// classified item held in the queue between front and back
	typedef struct packed {
		act_t                op;
		logic [SAMPLE_W-1:0] sample_ms;
	} qent_t;

	// report control carried from the estimator to the seconds pipeline
	typedef struct packed {
		logic               calc;     // RTO still to be formed from srtt/dev
		logic               give_up;
		logic [RETRY_W-1:0] retries;
	} rep_t;

endpackage

// File: rtl/rtt_rto_estimator_top.sv
// RTT/RTO estimator, top level: config registers, front queue, estimator and report pipeline.
// A result passes the estimator stage, the report stages s2, s3 and s4, and the output register.
// Throughput: one item per cycle while the output is not held; the bound is the srtt/dev/RTO update loop.
// Reset (arst_n, async, active low): srtt 0, dev 750 ms, RTO 3000 ms under reset bounds,
// retries 0, bounds 2 s / 60 s, retry limit 3, queue and pipeline empty.
// Depends on rre_pkg, rre_front, rre_core, rre_sec, rre_clamp.
module rtt_rto_estimator_top #(
	parameter int FRAC_BITS = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       evt_valid,
	output logic                       evt_ready,
	input  rre_pkg::evt_t              evt_data,
	output logic                       res_valid,
	input  logic                       res_ready,
	output rre_pkg::res_t              res_data,
	input  logic                       cfg_we,
	input  logic [1:0]                 cfg_idx,
	input  logic [rre_pkg::CFG_W-1:0]  cfg_wdata
);
	import rre_pkg::*;

	localparam int W_T   = SAMPLE_W + FRAC_BITS;
	localparam int W_B   = BOUND_MS_W + FRAC_BITS;
	localparam int W_RTO = W_T + 5;

	// Clamp bounds are kept pre-scaled (ms with fraction bits), so the
	// seconds-to-ms multiply happens once per config write, not per item.
	logic [W_B-1:0]     lo_q, hi_q;
	logic [LIMIT_W-1:0] max_retries_q;

	// front -> back queue handshake
	logic  q_valid, q_pop;
	qent_t q_ent;

	// estimator stage -> report pipeline
	logic             adv;
	logic             core_valid;
	rep_t             core_rep;
	logic [W_RTO-1:0] core_rto;
	logic [W_T-1:0]   core_srtt, core_dev;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_q          <= {BOUND_MS_W'(RST_MIN_S * MS_PER_S), {FRAC_BITS{1'b0}}};
			hi_q          <= {BOUND_MS_W'(RST_MAX_S * MS_PER_S), {FRAC_BITS{1'b0}}};
			max_retries_q <= LIMIT_W'(RST_MAX_RETRIES);
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_MIN_TIMEOUT: begin
					lo_q <= {BOUND_MS_W'(BOUND_MS_W'(cfg_wdata) * BOUND_MS_W'(MS_PER_S)),
						{FRAC_BITS{1'b0}}};
				end
				CFG_MAX_TIMEOUT: begin
					hi_q <= {BOUND_MS_W'(BOUND_MS_W'(cfg_wdata) * BOUND_MS_W'(MS_PER_S)),
						{FRAC_BITS{1'b0}}};
				end
				CFG_MAX_RETRIES: begin
					max_retries_q <= cfg_wdata[LIMIT_W-1:0];
				end
				default: begin
					// unused index: write is dropped
				end
			endcase
		end
	end

	// Front: classify and queue, so input acceptance continues while the
	// back side is held by a stalled output.
	rre_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt_valid (evt_valid),
		.evt_ready (evt_ready),
		.evt_data  (evt_data),
		.q_valid   (q_valid),
		.q_ent     (q_ent),
		.q_pop     (q_pop)
	);

	// Estimator: one item per cycle while the report pipeline advances; a sample leaves
	// the RTO to be formed from srtt/dev, which the next non-sample item or idle cycle settles.
	rre_core #(.FRAC_BITS(FRAC_BITS)) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_ent       (q_ent),
		.q_pop       (q_pop),
		.adv         (adv),
		.lo          (lo_q),
		.hi          (hi_q),
		.max_retries (max_retries_q),
		.valid_s1    (core_valid),
		.rep_s1      (core_rep),
		.rto_s1      (core_rto),
		.srtt_s1     (core_srtt),
		.dev_s1      (core_dev)
	);

	// Report pipeline: clamp, round to seconds, reciprocal multiply, output register.
	rre_sec #(.FRAC_BITS(FRAC_BITS)) u_sec (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (core_valid),
		.rep_s1    (core_rep),
		.rto_s1    (core_rto),
		.srtt_s1   (core_srtt),
		.dev_s1    (core_dev),
		.lo        (lo_q),
		.hi        (hi_q),
		.adv       (adv),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_data  (res_data)
	);

`ifndef SYNTH
	// a give-up always comes with a nonzero retry count
	a_giveup_count: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.give_up |-> res_data.retry_count != '0)
		else $error("give_up reported with zero retry count");

	// input is only refused while the queue holds items
	a_full_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		!evt_ready |-> q_valid)
		else $error("input refused with empty queue");

	// an item taken from the queue shows up in the estimator stage next cycle
	a_pop_to_s1: assert property (@(posedge clk) disable iff (!arst_n)
		q_valid && adv |=> core_valid)
		else $error("popped item lost before estimator stage");
`endif

endmodule

// File: rtl/rre_front.sv
// Front part: classifies incoming items and holds them in a two-entry queue.
// Depends on rre_pkg.
module rre_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           evt_valid,
	output logic           evt_ready,
	input  rre_pkg::evt_t  evt_data,
	output logic           q_valid,
	output rre_pkg::qent_t q_ent,
	input  logic           q_pop
);
	import rre_pkg::*;

	qent_t      ent;
	qent_t      mem_q [QUEUE_DEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push;

	// sample only matters for RTT samples; clear it elsewhere
	always_comb begin
		ent.sample_ms = '0;
		unique case (act_t'(evt_data.action))
			ACT_NEW: begin
				ent.op = ACT_NEW;
			end
			ACT_TIMEOUT: begin
				ent.op = ACT_TIMEOUT;
			end
			ACT_SAMPLE: begin
				ent.op        = ACT_SAMPLE;
				ent.sample_ms = evt_data.sample_ms;
			end
			ACT_NONE: begin
				ent.op = ACT_NONE;
			end
		endcase
	end

	assign evt_ready = (cnt_q != 2'(QUEUE_DEPTH));
	assign push      = evt_valid && evt_ready;
	assign q_valid   = (cnt_q != 2'd0);
	assign q_ent     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			unique case ({push, q_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// File: rtl/rre_clamp.sv
// RTO formation: srtt + 4*dev clamped to [lo, hi], lower bound tested first.
// Depends on rre_pkg.
module rre_clamp #(
	parameter int  FRAC_BITS = 8,
	localparam int W_T   = rre_pkg::SAMPLE_W + FRAC_BITS,
	localparam int W_B   = rre_pkg::BOUND_MS_W + FRAC_BITS,
	localparam int W_RTO = W_T + 5
) (
	input  logic [W_T-1:0]   srtt,
	input  logic [W_T-1:0]   dev,
	input  logic [W_B-1:0]   lo,
	input  logic [W_B-1:0]   hi,
	output logic [W_RTO-1:0] rto
);
	logic [W_T+2:0] sum;

	assign sum = {3'b000, srtt} + {1'b0, dev, 2'b00};

	always_comb begin
		priority if (sum < (W_T+3)'(lo)) begin
			rto = W_RTO'(lo);
		end else if (sum > (W_T+3)'(hi)) begin
			rto = W_RTO'(hi);
		end else begin
			rto = W_RTO'(sum);
		end
	end

endmodule

// File: rtl/rre_core.sv
// Back part, estimator stage: holds srtt, dev, RTO and retry count and applies one item a cycle while adv is high.
// Depends on rre_pkg and rre_clamp.
module rre_core #(
	parameter int  FRAC_BITS = 8,
	localparam int W_T   = rre_pkg::SAMPLE_W + FRAC_BITS,
	localparam int W_B   = rre_pkg::BOUND_MS_W + FRAC_BITS,
	localparam int W_RTO = W_T + 5
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_valid,
	input  rre_pkg::qent_t                q_ent,
	output logic                          q_pop,
	input  logic                          adv,
	input  logic [W_B-1:0]                lo,
	input  logic [W_B-1:0]                hi,
	input  logic [rre_pkg::LIMIT_W-1:0]   max_retries,
	output logic                          valid_s1,
	output rre_pkg::rep_t                 rep_s1,
	output logic [W_RTO-1:0]              rto_s1,
	output logic [W_T-1:0]                srtt_s1,
	output logic [W_T-1:0]                dev_s1
);
	import rre_pkg::*;

	localparam logic [W_T-1:0] DEV_RST = {SAMPLE_W'(RST_DEV_MS), {FRAC_BITS{1'b0}}};

	logic [W_T-1:0]     srtt_q, dev_q;
	logic [W_RTO-1:0]   rto_q;
	logic               stale_q;      // rto_q must be re-formed from srtt/dev
	logic [RETRY_W-1:0] retries_q;

	logic [W_T-1:0]     srtt_d, dev_d;
	logic [W_RTO-1:0]   rto_d;
	logic               stale_d;
	logic [RETRY_W-1:0] retries_d;

	logic [W_T-1:0]     smp;
	logic [W_T:0]       da, db, ea, eb;
	logic               dneg, eneg;
	logic [W_T-1:0]     mag, emag, srtt_n, dev_n;
	logic [W_RTO-1:0]   rto_clamp, rto_eff, rto_dbl, rep_rto;
	logic [RETRY_W-1:0] retries_inc, rep_retries;
	logic               gu, rep_calc, rep_gu;

	assign q_pop = q_valid && adv;

	rre_clamp #(.FRAC_BITS(FRAC_BITS)) u_clamp (
		.srtt (srtt_q),
		.dev  (dev_q),
		.lo   (lo),
		.hi   (hi),
		.rto  (rto_clamp)
	);

	assign rto_eff = stale_q ? rto_clamp : rto_q;
	// doubling saturates at all ones
	assign rto_dbl = rto_eff[W_RTO-1] ? '1 : {rto_eff[W_RTO-2:0], 1'b0};

	assign retries_inc = retries_q + RETRY_W'(1);
	assign gu          = retries_inc > {1'b0, max_retries};

	// sample update, both differences formed at once; divides truncate toward zero
	assign smp    = {q_ent.sample_ms, {FRAC_BITS{1'b0}}};
	assign da     = {1'b0, smp} - {1'b0, srtt_q};
	assign db     = {1'b0, srtt_q} - {1'b0, smp};
	assign dneg   = da[W_T];
	assign mag    = dneg ? db[W_T-1:0] : da[W_T-1:0];
	assign srtt_n = dneg ? (srtt_q - (mag >> 3)) : (srtt_q + (mag >> 3));

	assign ea     = {1'b0, mag} - {1'b0, dev_q};
	assign eb     = {1'b0, dev_q} - {1'b0, mag};
	assign eneg   = ea[W_T];
	assign emag   = eneg ? eb[W_T-1:0] : ea[W_T-1:0];
	assign dev_n  = eneg ? (dev_q - (emag >> 2)) : (dev_q + (emag >> 2));

	always_comb begin
		srtt_d      = srtt_q;
		dev_d       = dev_q;
		rto_d       = rto_q;
		stale_d     = stale_q;
		retries_d   = retries_q;
		rep_rto     = rto_eff;
		rep_calc    = 1'b0;
		rep_gu      = 1'b0;
		rep_retries = retries_q;
		if (q_pop) begin
			unique case (q_ent.op)
				ACT_NEW: begin
					retries_d   = '0;
					rep_retries = '0;
					rto_d       = rto_eff;
					stale_d     = 1'b0;
				end
				ACT_TIMEOUT: begin
					rto_d       = rto_dbl;
					stale_d     = 1'b0;
					rep_rto     = rto_dbl;
					rep_gu      = gu;
					rep_retries = retries_inc;
					retries_d   = retries_inc;
					if (gu) begin
						// back to initial estimate; RTO re-formed under current bounds
						srtt_d    = '0;
						dev_d     = DEV_RST;
						stale_d   = 1'b1;
						retries_d = '0;
					end
				end
				ACT_SAMPLE: begin
					srtt_d   = srtt_n;
					dev_d    = dev_n;
					stale_d  = 1'b1;
					rep_calc = 1'b1;
				end
				ACT_NONE: begin
					rto_d   = rto_eff;
					stale_d = 1'b0;
				end
			endcase
		end else if (stale_q) begin
			// idle cycle: settle the RTO from srtt/dev under the current bounds
			rto_d   = rto_eff;
			stale_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			srtt_q    <= '0;
			dev_q     <= DEV_RST;
			rto_q     <= '0;
			stale_q   <= 1'b1;
			retries_q <= '0;
			valid_s1  <= 1'b0;
		end else begin
			srtt_q    <= srtt_d;
			dev_q     <= dev_d;
			rto_q     <= rto_d;
			stale_q   <= stale_d;
			retries_q <= retries_d;
			if (adv) begin
				valid_s1 <= q_pop;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			rep_s1.calc    <= rep_calc;
			rep_s1.give_up <= rep_gu;
			rep_s1.retries <= rep_retries;
			rto_s1         <= rep_rto;
			srtt_s1        <= srtt_d;
			dev_s1         <= dev_d;
		end
	end

endmodule

// File: rtl/rre_sec.sv
// Back part, report pipeline: forms the reported RTO and rounds it to whole seconds.
// Depends on rre_pkg and rre_clamp.
module rre_sec #(
	parameter int  FRAC_BITS = 8,
	localparam int W_T   = rre_pkg::SAMPLE_W + FRAC_BITS,
	localparam int W_B   = rre_pkg::BOUND_MS_W + FRAC_BITS,
	localparam int W_RTO = W_T + 5
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             valid_s1,
	input  rre_pkg::rep_t    rep_s1,
	input  logic [W_RTO-1:0] rto_s1,
	input  logic [W_T-1:0]   srtt_s1,
	input  logic [W_T-1:0]   dev_s1,
	input  logic [W_B-1:0]   lo,
	input  logic [W_B-1:0]   hi,
	output logic             adv,
	output logic             res_valid,
	input  logic             res_ready,
	output rre_pkg::res_t    res_data
);
	import rre_pkg::*;

	localparam int P_W = SEC_DIV_W + RECIP_W;
	localparam logic [W_RTO:0] HALF_SCALED = (W_RTO+1)'(HALF_S_MS) << FRAC_BITS;

	logic [W_RTO-1:0]     rto_calc;
	logic [W_RTO:0]       rnd;
	logic [SEC_U_W-1:0]   u;

	logic                 valid_s2, valid_s3, valid_s4, valid_q;
	rep_t                 rep_s2, rep_s3, rep_s4;
	logic [W_RTO-1:0]     rto_s2;
	logic                 sat_s3, sat_s4;
	logic [SEC_DIV_W-1:0] w_s3;
	logic [P_W-1:0]       prod_s4;
	res_t                 res_q;

	rre_clamp #(.FRAC_BITS(FRAC_BITS)) u_clamp (
		.srtt (srtt_s1),
		.dev  (dev_s1),
		.lo   (lo),
		.hi   (hi),
		.rto  (rto_calc)
	);

	// whole pipeline moves whenever the output register is free or drained
	assign adv = !valid_q || res_ready;

	assign rnd = {1'b0, rto_s2} + HALF_SCALED;
	assign u   = rnd[W_RTO:FRAC_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_q  <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_q  <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rto_s2  <= rep_s1.calc ? rto_calc : rto_s1;
			rep_s2  <= rep_s1;
			// secs = u / 1000 = (u >> 3) / 125, exact by reciprocal below the saturation point
			sat_s3  <= u >= SEC_U_W'(U_SAT);
			w_s3    <= u[SEC_DIV_W+2:3];
			rep_s3  <= rep_s2;
			prod_s4 <= P_W'(w_s3) * P_W'(RECIP_125);
			sat_s4  <= sat_s3;
			rep_s4  <= rep_s3;
			res_q.timeout_s   <= sat_s4 ? SEC_W'(SEC_SAT) : prod_s4[RECIP_SH+SEC_W-1:RECIP_SH];
			res_q.give_up     <= rep_s4.give_up;
			res_q.retry_count <= rep_s4.retries;
		end
	end

	assign res_valid = valid_q;
	assign res_data  = res_q;

endmodule

// File: verif/rtt_rto_estimator_top_tb.sv
// Testbench for rtt_rto_estimator_top: directed and random event items, checked
// against an in-bench estimator by a small scoreboard class.
// Depends on rre_pkg and the RTL under rtl/.
module rtt_rto_estimator_top_tb;
	import rre_pkg::*;

	localparam int FRAC_BITS  = 8;
	localparam int IDLE_LIMIT = 4000;  // cycles with no handshake before giving up
	localparam int HOLD_LEN   = 300;   // long receiver hold-off, cycles
	localparam int PHASES     = 8;
	localparam int PHASE_ITEMS = 235;

	// index 3 is not a register; writes there must be ignored
	localparam logic [1:0] CFG_SPARE = 2'd3;

	// Scoreboard: carries its own copy of the estimator and registers, and a
	// queue of the result items each accepted event will produce.
	class rto_checker #(parameter int FRAC = 8);
		localparam longint unsigned RTO_CAP = (64'd1 << (25 + FRAC)) - 64'd1;

		logic [CFG_W-1:0]   min_s;
		logic [CFG_W-1:0]   max_s;
		logic [LIMIT_W-1:0] retry_lim;
		logic [27:0]        srtt;
		logic [27:0]        rttvar;
		logic [32:0]        rto;
		logic [RETRY_W-1:0] retries;
		res_t               due_q[$];
		int                 errors;
		int                 n_seen;

		function new();
			min_s     = CFG_W'(RST_MIN_S);
			max_s     = CFG_W'(RST_MAX_S);
			retry_lim = LIMIT_W'(RST_MAX_RETRIES);
			errors    = 0;
			n_seen    = 0;
			restart();
		endfunction

		function logic [32:0] clamp_rto(longint unsigned v);
			longint unsigned lo, hi;
			lo = min_s;
			hi = max_s;
			lo = (lo * MS_PER_S) << FRAC;
			hi = (hi * MS_PER_S) << FRAC;
			// low bound tested first, so min > max lets low values reach min
			if (v < lo)
				return lo[32:0];
			if (v > hi)
				return hi[32:0];
			return v[32:0];
		endfunction

		function void restart();
			longint unsigned dev;
			dev     = RST_DEV_MS;
			dev     = dev << FRAC;
			srtt    = '0;
			rttvar  = dev[27:0];
			rto     = clamp_rto(dev * 4);
			retries = '0;
		endfunction

		function void write_reg(logic [1:0] idx, logic [CFG_W-1:0] d);
			case (idx)
				CFG_MIN_TIMEOUT: min_s = d;
				CFG_MAX_TIMEOUT: max_s = d;
				CFG_MAX_RETRIES: retry_lim = d[LIMIT_W-1:0];
				default: ;
			endcase
		endfunction

		function void predict_event(evt_t e);
			longint          s_fx, cur, delta, mag, dev;
			longint unsigned v, secs;
			logic            gu;
			logic [32:0]     rep_rto;
			logic [4:0]      rep_ret;
			res_t            r;
			gu = 1'b0;
			case (act_t'(e.action))
				ACT_NEW: begin
					retries = '0;
				end
				ACT_TIMEOUT: begin
					v = rto;
					// doubling is not clamped, only saturated
					if (v > RTO_CAP / 2)
						rto = RTO_CAP[32:0];
					else
						rto = 33'(v * 2);
					retries = retries + 5'd1;
					gu = (retries > retry_lim);
				end
				ACT_SAMPLE: begin
					s_fx  = e.sample_ms;
					s_fx  = s_fx << FRAC;
					cur   = srtt;
					delta = s_fx - cur;
					mag   = (delta < 0) ? -delta : delta;
					dev   = rttvar;
					// signed divides truncate toward zero
					cur    = cur + delta / 8;
					dev    = dev + (mag - dev) / 4;
					srtt   = cur[27:0];
					rttvar = dev[27:0];
					v      = cur + 4 * dev;
					rto    = clamp_rto(v);
				end
				default: ;  // unused code: state untouched
			endcase
			rep_rto = rto;
			rep_ret = retries;
			if (gu)
				restart();
			v    = rep_rto;
			secs = (v + (HALF_S_MS << FRAC)) / (MS_PER_S << FRAC);
			if (secs > SEC_SAT)
				secs = SEC_SAT;
			r.timeout_s   = secs[SEC_W-1:0];
			r.give_up     = gu;
			r.retry_count = rep_ret;
			due_q.push_back(r);
		endfunction

		task report_mismatch(string what, longint got, longint want);
			$display("mismatch at result %0d: %s got %0d want %0d", n_seen, what, got, want);
			errors++;
		endtask

		task check_result(res_t r);
			res_t w;
			n_seen++;
			if (due_q.size() == 0) begin
				report_mismatch("unexpected result, timeout_s", r.timeout_s, 0);
				return;
			end
			w = due_q.pop_front();
			if (r.timeout_s !== w.timeout_s)
				report_mismatch("timeout_s", r.timeout_s, w.timeout_s);
			if (r.give_up !== w.give_up)
				report_mismatch("give_up", r.give_up, w.give_up);
			if (r.retry_count !== w.retry_count)
				report_mismatch("retry_count", r.retry_count, w.retry_count);
		endtask

		function int pending();
			return due_q.size();
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             evt_valid;
	logic             evt_ready;
	evt_t             evt_data;
	logic             res_valid;
	logic             res_ready;
	res_t             res_data;
	logic             cfg_we;
	logic [1:0]       cfg_idx;
	logic [CFG_W-1:0] cfg_wdata;

	rto_checker #(FRAC_BITS) chk;

	int idle_cycles;
	int burst_left;
	bit idle_on;     // sender inserts gaps between bursts when set
	bit hold_req;    // asks the receiver for one long hold-off
	int hold_left;

	rtt_rto_estimator_top #(
		.FRAC_BITS(FRAC_BITS)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.evt_valid(evt_valid),
		.evt_ready(evt_ready),
		.evt_data (evt_data),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res_data (res_data),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Monitor and watchdog: everything sampled at the rising edge, before the
	// block's registers move.
	always @(posedge clk) begin
		if (arst_n) begin
			if (evt_valid && evt_ready)
				chk.predict_event(evt_data);
			if (res_valid && res_ready)
				chk.check_result(res_data);
			if ((evt_valid && evt_ready) || (res_valid && res_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	// Receiver: switches between stall patterns every so often; a hold request
	// from the main flow forces one long stretch with ready low.
	initial begin
		int mode;
		int left;
		bit held;
		res_ready = 1'b0;
		hold_left = 0;
		mode      = 0;
		left      = 0;
		held      = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req && !held) begin
				held      = 1'b1;
				hold_left = HOLD_LEN;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_ready = 1'b0;
			end else begin
				if (left == 0) begin
					mode = $urandom_range(0, 3);
					left = $urandom_range(10, 150);
				end
				left--;
				case (mode)
					0: res_ready = 1'b1;
					1: res_ready = 1'($urandom_range(0, 1));
					2: res_ready = ($urandom_range(0, 3) == 0);
					default: res_ready = ~res_ready;
				endcase
			end
		end
	end

	function automatic evt_t mk_evt(act_t a, logic [SAMPLE_W-1:0] s);
		evt_t e;
		e.action    = a;
		e.sample_ms = s;
		return e;
	endfunction

	// Random sample value: mostly realistic RTTs, some wide and extreme ones.
	function automatic logic [SAMPLE_W-1:0] rand_sample();
		int k;
		k = $urandom_range(0, 9);
		if (k < 5)
			return SAMPLE_W'($urandom_range(0, 4000));
		if (k < 7)
			return SAMPLE_W'($urandom_range(0, 300000));
		if (k == 7)
			return ($urandom_range(0, 1) != 0) ? '1 : '0;
		return SAMPLE_W'($urandom());
	endfunction

	function automatic evt_t rand_evt();
		int r;
		r = $urandom_range(0, 99);
		if (r < 15)
			return mk_evt(ACT_NEW, SAMPLE_W'($urandom()));
		if (r < 50)
			return mk_evt(ACT_TIMEOUT, SAMPLE_W'($urandom()));
		if (r < 95)
			return mk_evt(ACT_SAMPLE, rand_sample());
		return mk_evt(ACT_NONE, SAMPLE_W'($urandom()));
	endfunction

	// Offer one item; called and returns at a falling edge. Valid stays high
	// across back-to-back items and only drops for a gap.
	task automatic send_evt(evt_t e);
		int gap;
		if (idle_on) begin
			if (burst_left == 0) begin
				gap        = $urandom_range(1, 6);
				burst_left = $urandom_range(1, 24);
				evt_valid  = 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left--;
		end
		evt_valid = 1'b1;
		evt_data  = e;
		@(posedge clk);
		while (!evt_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Stop offering and wait for every expected item, plus the pipeline depth.
	task automatic wait_drained();
		evt_valid = 1'b0;
		while (chk.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_cfg(logic [1:0] idx, logic [CFG_W-1:0] d);
		cfg_we    = 1'b1;
		cfg_idx   = idx;
		cfg_wdata = d;
		chk.write_reg(idx, d);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic configure(int p);
		logic [CFG_W-1:0] lo, hi, lim;
		case (p)
			0: begin
				lo  = CFG_W'(RST_MIN_S);
				hi  = CFG_W'(RST_MAX_S);
				lim = CFG_W'(RST_MAX_RETRIES);
			end
			1: begin
				lo  = 8'd0;
				hi  = 8'd255;
				lim = 8'hFF;   // upper bits dropped, limit 15
			end
			2: begin
				lo  = 8'd0;
				hi  = 8'd0;
				lim = 8'd0;
			end
			3: begin
				lo  = 8'd255;
				hi  = 8'd255;
				lim = 8'd1;
			end
			4: begin
				lo  = 8'd200;  // crossed bounds
				hi  = 8'd10;
				lim = 8'd5;
			end
			default: begin
				lo  = CFG_W'($urandom());
				hi  = CFG_W'($urandom());
				lim = CFG_W'($urandom());
			end
		endcase
		write_cfg(CFG_MIN_TIMEOUT, lo);
		write_cfg(CFG_MAX_TIMEOUT, hi);
		write_cfg(CFG_MAX_RETRIES, lim);
		if (p == 5)
			write_cfg(CFG_SPARE, CFG_W'($urandom()));
	endtask

	task automatic run_random(int n);
		int cnt;
		int run;
		cnt = 0;
		while (cnt < n) begin
			// a run of timeouts long enough to hit give-up under the current limit
			if ($urandom_range(0, 9) == 0) begin
				run = int'(chk.retry_lim) + 1 + $urandom_range(0, 1);
				repeat (run) begin
					send_evt(mk_evt(ACT_TIMEOUT, SAMPLE_W'($urandom())));
					cnt++;
				end
			end else begin
				send_evt(rand_evt());
				cnt++;
			end
		end
	endtask

	initial begin
		arst_n      = 1'b0;
		evt_valid   = 1'b0;
		evt_data    = '0;
		cfg_we      = 1'b0;
		cfg_idx     = '0;
		cfg_wdata   = '0;
		hold_req    = 1'b0;
		idle_cycles = 0;
		burst_left  = 0;
		idle_on     = 1'b1;
		chk         = new();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed, reset registers: unused code, sample extremes, a sample well
		// below srtt, timeouts up to give-up, new packet, ignored sample fields.
		send_evt(mk_evt(ACT_NONE, '0));
		send_evt(mk_evt(ACT_SAMPLE, '0));
		send_evt(mk_evt(ACT_SAMPLE, '1));
		send_evt(mk_evt(ACT_SAMPLE, 20'd1));
		send_evt(mk_evt(ACT_SAMPLE, 20'd500));
		repeat (4) send_evt(mk_evt(ACT_TIMEOUT, SAMPLE_W'($urandom())));
		send_evt(mk_evt(ACT_NEW, '0));
		send_evt(mk_evt(ACT_TIMEOUT, '1));
		send_evt(mk_evt(ACT_NEW, '1));
		send_evt(mk_evt(ACT_SAMPLE, 20'd2500));
		send_evt(mk_evt(ACT_NONE, '1));
		wait_drained();

		// Directed, highest bounds and top limit: RTO doubling runs into its
		// saturation and the seconds field saturates too.
		write_cfg(CFG_MIN_TIMEOUT, 8'd255);
		write_cfg(CFG_MAX_TIMEOUT, 8'd255);
		write_cfg(CFG_MAX_RETRIES, 8'hFF);
		send_evt(mk_evt(ACT_SAMPLE, '1));
		repeat (11) send_evt(mk_evt(ACT_TIMEOUT, SAMPLE_W'($urandom())));

		// Random phases, each under its own register setting. Phase 2 runs the
		// sender flat out against a long receiver hold-off so the block backs up.
		for (int p = 0; p < PHASES; p++) begin
			wait_drained();
			configure(p);
			idle_on = (p % 3 != 2);
			if (p == 2)
				hold_req = 1'b1;
			run_random(PHASE_ITEMS);
		end
		wait_drained();

		if (chk.errors == 0 && chk.pending() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule
